// File: sv/assert_macros.svh
// assertion macros shared by the bucket priority queue modules
// no dependencies; included by the controller and the datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: sv/bmpq_pkg.sv
// shared types and constants for the bucket max priority queue
// no dependencies; used by the controller, datapath and top level
`default_nettype none

package bmpq_pkg;

  localparam int KEY_W   = 7;
  localparam int COUNT_W = 16;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic update;
    logic seek;
  } ctl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic seek_req;
  } dp_sts_t;

endpackage

`default_nettype wire

// File: sv/bmpq_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module bmpq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: sv/bmpq_ctrl.sv
// controller state machine: accept, bucket update, next-maximum search
// depends on bmpq_pkg and assert_macros.svh
`default_nettype none

module bmpq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  output bmpq_pkg::ctl_cmd_t      cmd,
  input  wire bmpq_pkg::dp_sts_t  sts
);

  import bmpq_pkg::*;

  `include "assert_macros.svh"

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPD,
    ST_SEEK
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = sts.seek_req ? ST_SEEK : ST_IDLE;
      end
      ST_SEEK: begin
        cmd.seek  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    busy_nxt = (state_nxt != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy = busy_r;

  `ASSERT_IMPL(a_busy_tracks_state, clk, rst_n, 1'b1, busy_r == (state_r != ST_IDLE))
  `ASSERT_NEXT(a_accept_then_update, clk, rst_n, cmd.accept, state_r == ST_UPD)
  `ASSERT_NEXT(a_seek_after_update, clk, rst_n, state_r == ST_SEEK, state_r == ST_IDLE)

endmodule

`default_nettype wire

// File: sv/bmpq_dp.sv
// datapath: bucket count ram, nonzero bitmap, total, running maximum, result registers
// depends on bmpq_pkg, bmpq_ram and assert_macros.svh
`default_nettype none

module bmpq_dp #(
  parameter int NUM_KEYS    = 128,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire bmpq_pkg::ctl_cmd_t                cmd,
  output bmpq_pkg::dp_sts_t                      sts,
  input  wire logic                              in_kind,
  input  wire logic [bmpq_pkg::KEY_W-1:0]        in_key,
  output logic                                   out_valid,
  output logic      [bmpq_pkg::KEY_W-1:0]        out_popped_key,
  output logic                                   out_was_empty,
  output logic                                   out_push_refused,
  output logic      [bmpq_pkg::COUNT_W-1:0]      out_item_count
);

  import bmpq_pkg::*;

  `include "assert_macros.svh"

  localparam int KW = $clog2(NUM_KEYS);
  localparam int CW = COUNT_WIDTH;

  // request latched at accept
  logic          kind_r;
  logic          key_ok_r;
  logic [KW-1:0] addr_r;

  logic [NUM_KEYS-1:0] bitmap_r, bitmap_nxt;
  logic [CW-1:0]       total_r, total_nxt;
  logic [KW-1:0]       highest_r, highest_nxt;

  logic                out_valid_r;
  logic [KEY_W-1:0]    popped_r, popped_nxt;
  logic                empty_r, empty_nxt;
  logic                refused_r, refused_nxt;
  logic [COUNT_W-1:0]  count_r;

  logic [KW-1:0] key_idx;
  logic          key_ok;
  logic [KW-1:0] rd_addr;
  logic [CW-1:0] rd_data;
  logic [CW-1:0] cnt_cur;
  logic [CW-1:0] wr_data;
  logic          wr_en;
  logic          push_ok;
  logic          pop_ok;
  logic [KW-1:0] seek_idx;

  assign key_idx = KW'(in_key);
  assign key_ok  = (32'(in_key) < NUM_KEYS);
  assign rd_addr = (in_kind == KIND_POP) ? highest_r : key_idx;

  bmpq_ram #(
    .WIDTH (CW),
    .DEPTH (NUM_KEYS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (addr_r),
    .wdata (wr_data),
    .re    (cmd.accept),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // a bucket whose bitmap bit is clear holds zero, whatever the ram says
  assign cnt_cur = bitmap_r[addr_r] ? rd_data : '0;

  assign push_ok = (kind_r == KIND_PUSH) && key_ok_r && (total_r != {CW{1'b1}});
  assign pop_ok  = (kind_r == KIND_POP) && (total_r != '0);

  assign sts.seek_req = pop_ok;

  // highest set bit of the nonzero bitmap
  always_comb begin
    seek_idx = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (bitmap_r[i]) begin
        seek_idx = KW'(i);
      end
    end
  end

  always_comb begin
    bitmap_nxt  = bitmap_r;
    total_nxt   = total_r;
    highest_nxt = highest_r;
    wr_en       = 1'b0;
    wr_data     = cnt_cur + 1'b1;
    popped_nxt  = '0;
    empty_nxt   = (kind_r == KIND_POP) && (total_r == '0);
    refused_nxt = (kind_r == KIND_PUSH) && !push_ok;
    if (cmd.update && push_ok) begin
      wr_en              = 1'b1;
      bitmap_nxt[addr_r] = 1'b1;
      total_nxt          = total_r + 1'b1;
      if ((total_r == '0) || (addr_r > highest_r)) begin
        highest_nxt = addr_r;
      end
    end else if (cmd.update && pop_ok) begin
      wr_en      = 1'b1;
      wr_data    = cnt_cur - 1'b1;
      total_nxt  = total_r - 1'b1;
      popped_nxt = KEY_W'(addr_r);
      if (cnt_cur == CW'(1)) begin
        bitmap_nxt[addr_r] = 1'b0;
      end
    end
    if (cmd.seek) begin
      // an empty bitmap gives zero, as the queue requires when it drains
      highest_nxt = seek_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bitmap_r    <= '0;
      total_r     <= '0;
      highest_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      bitmap_r    <= bitmap_nxt;
      total_r     <= total_nxt;
      highest_r   <= highest_nxt;
      out_valid_r <= cmd.update;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r   <= in_kind;
      key_ok_r <= key_ok;
      addr_r   <= rd_addr;
    end
    if (cmd.update) begin
      popped_r  <= popped_nxt;
      empty_r   <= empty_nxt;
      refused_r <= refused_nxt;
      count_r   <= COUNT_W'(total_nxt);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_popped_key   = popped_r;
  assign out_was_empty    = empty_r;
  assign out_push_refused = refused_r;
  assign out_item_count   = count_r;

  `ASSERT_IMPL(a_empty_bitmap, clk, rst_n, total_r == '0, bitmap_r == '0)
  `ASSERT_IMPL(a_empty_result, clk, rst_n, out_valid_r && empty_r, total_r == '0)
  `ASSERT_IMPL(a_one_op_flag, clk, rst_n, cmd.update, !(pop_ok && push_ok))

endmodule

`default_nettype wire

// File: sv/bucket_max_priority_queue.sv
// Max priority queue over small keys, one occurrence count per key in a ram,
// with a nonzero bitmap whose priority encoder finds the next maximum. A
// request is taken when start is high and busy is low. A push, a refused
// push and a pop of an empty queue are accepted in the idle state and finish
// in the update state; a pop that removes a key also passes through the seek
// state, the priority-encoder search for the new maximum. The result strobe
// out_valid is high for one cycle, registered from the update state, and cannot
// be stalled. Reset clears the bitmap at once, so no clearing pass is needed.
// depends on bmpq_pkg, bmpq_ctrl and bmpq_dp
`default_nettype none

module bucket_max_priority_queue #(
  parameter int NUM_KEYS    = 128,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_kind,
  input  wire logic [bmpq_pkg::KEY_W-1:0]    in_key,
  output logic                               out_valid,
  output logic      [bmpq_pkg::KEY_W-1:0]    out_popped_key,
  output logic                               out_was_empty,
  output logic                               out_push_refused,
  output logic      [bmpq_pkg::COUNT_W-1:0]  out_item_count
);

  import bmpq_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  bmpq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  bmpq_dp #(
    .NUM_KEYS    (NUM_KEYS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_kind          (in_kind),
    .in_key           (in_key),
    .out_valid        (out_valid),
    .out_popped_key   (out_popped_key),
    .out_was_empty    (out_was_empty),
    .out_push_refused (out_push_refused),
    .out_item_count   (out_item_count)
  );

endmodule

`default_nettype wire
